>>> sv/twwp_pkg.sv
// Shared types, constants and the sine table of the turntable projection block.
package twwp_pkg;

    // Angle units per turn and the quarter turn that turns sine into cosine.
    localparam int ANGLE_STEPS = 360;
    localparam int QUARTER     = ANGLE_STEPS / 4;

    // Register reset values.
    localparam int YAW_RST    = 35;
    localparam int PITCH_RST  = -18;
    localparam int CENTRE_RST = 0;
    localparam int SCALE_RST  = 256;
    localparam int PK_RST     = 0;

    // Configuration register indexes.
    localparam logic [2:0] CFG_YAW      = 3'd0;
    localparam logic [2:0] CFG_PITCH    = 3'd1;
    localparam logic [2:0] CFG_CENTRE_X = 3'd2;
    localparam logic [2:0] CFG_CENTRE_Y = 3'd3;
    localparam logic [2:0] CFG_SCALE    = 3'd4;
    localparam logic [2:0] CFG_PERSP_K  = 3'd5;

    // Number of quotient bits produced by the divider stages.
    localparam int QBITS = 16;

    // Trig reload sequencer states.
    typedef enum logic [2:0] {
        TS_IDLE,
        TS_RD_SY,
        TS_RD_CY,
        TS_RD_SP,
        TS_RD_CP,
        TS_RD_END
    } t_trig_state;

    // Settings used by the datapath.
    typedef struct packed {
        logic [15:0] centre_x;
        logic [15:0] centre_y;
        logic [15:0] scale;
        logic [15:0] persp_k;
    } t_cfg;

    // Sine and cosine of yaw and pitch, Q1.14.
    typedef struct packed {
        logic signed [15:0] sy;
        logic signed [15:0] cy;
        logic signed [15:0] sp;
        logic signed [15:0] cp;
    } t_trig;

    // Rotated point leaving the rotation pipeline.
    typedef struct packed {
        logic               valid;
        logic signed [17:0] x1;
        logic signed [18:0] y2;
        logic signed [18:0] z2;
    } t_pt;

    // Perspective factor leaving the divider.
    typedef struct packed {
        logic               valid;
        logic               sat;
        logic [QBITS-1:0]   q;
        logic signed [17:0] x1;
        logic signed [18:0] y2;
        logic signed [18:0] z2;
    } t_pf;

    typedef logic signed [ANGLE_STEPS-1:0] [15:0] t_sin_rom;

    // Sine of a Q0.32 turn phase, Q1.14, from a fixed-point Taylor series.
    function automatic logic signed [15:0] sin_of_phase(input logic [31:0] t);
        logic [63:0] one_q30;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        logic [15:0] v;
        one_q30 = 64'd1 << 30;
        r = {34'd0, t[29:0]};
        if (t[30]) begin
            r = one_q30 - r;
        end
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        h  = one_q30;
        h  = one_q30 - ((x2 * h) >> 30) / 64'd110;
        h  = one_q30 - ((x2 * h) >> 30) / 64'd72;
        h  = one_q30 - ((x2 * h) >> 30) / 64'd42;
        h  = one_q30 - ((x2 * h) >> 30) / 64'd20;
        h  = one_q30 - ((x2 * h) >> 30) / 64'd6;
        s  = (x * h) >> 30;
        v  = 16'((s + 64'd32768) >> 16);
        return t[31] ? -$signed(v) : $signed(v);
    endfunction

    // Sine table over one turn, one entry per angle unit.
    function automatic t_sin_rom build_sin_rom();
        t_sin_rom rom;
        logic [63:0] ph;
        for (int p = 0; p < ANGLE_STEPS; p++) begin
            ph = (64'(p) << 32) / 64'(ANGLE_STEPS);
            rom[p] = sin_of_phase(ph[31:0]);
        end
        return rom;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

endpackage

>>> sv/turntable_weak_perspective_project_top.sv
// Top level of the turntable rotation and weak-perspective projection block.
//
// A point request (i_atom_x/y/z, signed Q8.8) is taken at a rising edge where
// start is high and busy is low. One result is on the o_ ports for exactly
// one cycle, marked by o_valid. A new point can be taken every cycle while
// busy is low; the result passes through the rotation multipliers (4 stages),
// the denominator (2 stages), the divider setup and its 16 one-bit
// compare-subtract stages, and 3 scaling and clamp stages. The receiver
// cannot stall, so results are never held back.
//
// Registers are written through i_cfg_valid/o_cfg_ready, i_cfg_index and
// i_cfg_data. A yaw or pitch write reloads sine and cosine from the internal
// table, which keeps busy high and o_cfg_ready low through the read states.
// Writes to indexes past the register list are ignored.
// Synchronous reset restores the register reset values and their sine and
// cosine, empties the pipeline and leaves the block ready at once.
module turntable_weak_perspective_project_top import twwp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_atom_x,
    input  logic signed [15:0] i_atom_y,
    input  logic signed [15:0] i_atom_z,
    output logic               o_valid,
    output logic signed [19:0] o_screen_x,
    output logic signed [19:0] o_screen_y,
    output logic signed [15:0] o_depth,
    output logic [15:0]        o_persp,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg  cfg;
    t_trig trig;
    t_pt   pt;
    t_pf   pfv;
    logic  accept;

    assign accept = start && !busy;

    twwp_trig u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_cfg       (cfg),
        .o_trig      (trig)
    );

    twwp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ax    (i_atom_x),
        .i_ay    (i_atom_y),
        .i_az    (i_atom_z),
        .i_trig  (trig),
        .o_pt    (pt)
    );

    twwp_persp u_persp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (pt),
        .i_persp_k (cfg.persp_k),
        .o_pf      (pfv)
    );

    twwp_screen u_screen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pf       (pfv),
        .i_cfg      (cfg),
        .o_valid    (o_valid),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .o_depth    (o_depth),
        .o_persp    (o_persp),
        .o_overflow (o_overflow)
    );

endmodule

>>> sv/twwp_trig.sv
// Configuration registers and the sine/cosine reload sequencer.
module twwp_trig import twwp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_busy,
    output t_cfg        o_cfg,
    output t_trig       o_trig
);

    t_trig_state r_state, n_state;
    logic [8:0]        r_yaw;
    logic signed [7:0] r_pitch;
    t_cfg              r_cfg;
    t_trig             r_trig;
    logic signed [15:0] r_rom_q;

    logic       cfg_wr;
    logic       angle_wr;
    logic [8:0] yaw_idx;
    logic [9:0] ycos_sum;
    logic [8:0] ycos_idx;
    logic signed [9:0] p_ext;
    logic signed [9:0] p_wrap;
    logic [8:0] pit_idx;
    logic [9:0] pcos_sum;
    logic [8:0] pcos_idx;
    logic [8:0] rom_addr;
    logic cap_sy, cap_cy, cap_sp, cap_cp;

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign angle_wr    = cfg_wr && (i_cfg_index == CFG_YAW || i_cfg_index == CFG_PITCH);
    assign o_cfg_ready = (r_state == TS_IDLE);
    assign o_busy      = (r_state != TS_IDLE);
    assign o_cfg       = r_cfg;
    assign o_trig      = r_trig;

    // Reduce the angles into one turn and offset by a quarter for cosine.
    always_comb begin
        yaw_idx  = (r_yaw >= 9'(ANGLE_STEPS)) ? r_yaw - 9'(ANGLE_STEPS) : r_yaw;
        ycos_sum = {1'b0, yaw_idx} + 10'(QUARTER);
        ycos_idx = (ycos_sum >= 10'(ANGLE_STEPS)) ? 9'(ycos_sum - 10'(ANGLE_STEPS))
                                                  : ycos_sum[8:0];
        p_ext    = 10'(r_pitch);
        p_wrap   = (p_ext < 10'sd0) ? p_ext + 10'(ANGLE_STEPS) : p_ext;
        pit_idx  = p_wrap[8:0];
        pcos_sum = {1'b0, pit_idx} + 10'(QUARTER);
        pcos_idx = (pcos_sum >= 10'(ANGLE_STEPS)) ? 9'(pcos_sum - 10'(ANGLE_STEPS))
                                                  : pcos_sum[8:0];
    end

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw            <= 9'(YAW_RST);
            r_pitch          <= 8'(PITCH_RST);
            r_cfg.centre_x   <= 16'(CENTRE_RST);
            r_cfg.centre_y   <= 16'(CENTRE_RST);
            r_cfg.scale      <= 16'(SCALE_RST);
            r_cfg.persp_k    <= 16'(PK_RST);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_YAW:      r_yaw          <= i_cfg_data[8:0];
                CFG_PITCH:    r_pitch        <= i_cfg_data[7:0];
                CFG_CENTRE_X: r_cfg.centre_x <= i_cfg_data;
                CFG_CENTRE_Y: r_cfg.centre_y <= i_cfg_data;
                CFG_SCALE:    r_cfg.scale    <= i_cfg_data;
                CFG_PERSP_K:  r_cfg.persp_k  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a yaw or pitch write reloads all four values.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE:   n_state = angle_wr ? TS_RD_SY : TS_IDLE;
            TS_RD_SY:  n_state = TS_RD_CY;
            TS_RD_CY:  n_state = TS_RD_SP;
            TS_RD_SP:  n_state = TS_RD_CP;
            TS_RD_CP:  n_state = TS_RD_END;
            TS_RD_END: n_state = TS_IDLE;
            default:   n_state = TS_IDLE;
        endcase
    end

    // Outputs: table address issued and which value captures the read data.
    always_comb begin
        rom_addr = yaw_idx;
        cap_sy   = 1'b0;
        cap_cy   = 1'b0;
        cap_sp   = 1'b0;
        cap_cp   = 1'b0;
        unique case (r_state)
            TS_IDLE:   rom_addr = yaw_idx;
            TS_RD_SY:  rom_addr = yaw_idx;
            TS_RD_CY: begin
                rom_addr = ycos_idx;
                cap_sy   = 1'b1;
            end
            TS_RD_SP: begin
                rom_addr = pit_idx;
                cap_cy   = 1'b1;
            end
            TS_RD_CP: begin
                rom_addr = pcos_idx;
                cap_sp   = 1'b1;
            end
            TS_RD_END: cap_cp = 1'b1;
            default:   rom_addr = yaw_idx;
        endcase
    end

    // Sine table read with registered data.
    always_ff @(posedge i_clk) begin
        r_rom_q <= SIN_ROM[rom_addr];
    end

    // Trig values, reset to those of the reset angles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig.sy <= SIN_ROM[YAW_RST];
            r_trig.cy <= SIN_ROM[(YAW_RST + QUARTER) % ANGLE_STEPS];
            r_trig.sp <= SIN_ROM[PITCH_RST + ANGLE_STEPS];
            r_trig.cp <= SIN_ROM[(PITCH_RST + ANGLE_STEPS + QUARTER) % ANGLE_STEPS];
        end else begin
            if (cap_sy) r_trig.sy <= r_rom_q;
            if (cap_cy) r_trig.cy <= r_rom_q;
            if (cap_sp) r_trig.sp <= r_rom_q;
            if (cap_cp) r_trig.cp <= r_rom_q;
        end
    end

endmodule

>>> sv/twwp_rotate.sv
// Four-stage yaw then pitch rotation pipeline.
module twwp_rotate import twwp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_az,
    input  t_trig              i_trig,
    output t_pt                o_pt
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [31:0] r_pxc, r_pzs, r_pzc, r_pxs;
    logic signed [15:0] r_ay1, r_ay2;
    logic signed [17:0] r_x1_2, r_z1, r_x1_3, r_x1_4;
    logic signed [31:0] r_pyc, r_pys;
    logic signed [33:0] r_pzsp, r_pzcp;
    logic signed [18:0] r_y2, r_z2;

    logic signed [32:0] sum_x1, sum_z1;
    logic signed [34:0] sum_y2, sum_z2;

    // Round half up on the way from Q.22 back to Q8.8.
    always_comb begin
        sum_x1 = 33'(r_pxc) + 33'(r_pzs) + 33'sd8192;
        sum_z1 = 33'(r_pzc) - 33'(r_pxs) + 33'sd8192;
        sum_y2 = 35'(r_pyc) - 35'(r_pzsp) + 35'sd8192;
        sum_z2 = 35'(r_pys) + 35'(r_pzcp) + 35'sd8192;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Yaw products, yaw sums, pitch products, pitch sums.
    always_ff @(posedge i_clk) begin
        r_pxc  <= i_ax * i_trig.cy;
        r_pzs  <= i_az * i_trig.sy;
        r_pzc  <= i_az * i_trig.cy;
        r_pxs  <= i_ax * i_trig.sy;
        r_ay1  <= i_ay;

        r_x1_2 <= 18'(sum_x1 >>> 14);
        r_z1   <= 18'(sum_z1 >>> 14);
        r_ay2  <= r_ay1;

        r_pyc  <= r_ay2 * i_trig.cp;
        r_pys  <= r_ay2 * i_trig.sp;
        r_pzsp <= 34'(r_z1) * 34'(i_trig.sp);
        r_pzcp <= 34'(r_z1) * 34'(i_trig.cp);
        r_x1_3 <= r_x1_2;

        r_y2   <= 19'(sum_y2 >>> 14);
        r_z2   <= 19'(sum_z2 >>> 14);
        r_x1_4 <= r_x1_3;
    end

    assign o_pt.valid = r_v4;
    assign o_pt.x1    = r_x1_4;
    assign o_pt.y2    = r_y2;
    assign o_pt.z2    = r_z2;

endmodule

>>> sv/twwp_persp.sv
// Denominator and pipelined restoring divider for the perspective factor.
module twwp_persp import twwp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pt         i_pt,
    input  logic [15:0] i_persp_k,
    output t_pf         o_pf
);

    typedef struct packed {
        logic               valid;
        logic               sat;
        logic [52:0]        rem;
        logic [35:0]        den;
        logic [QBITS-1:0]   q;
        logic signed [17:0] x1;
        logic signed [18:0] y2;
        logic signed [18:0] z2;
    } t_div_stg;

    t_pt                r_p5;
    logic signed [35:0] r_prod;
    t_pt                r_p6;
    logic [35:0]        r_den;
    logic               r_floor;
    t_div_stg           r_stg [QBITS+1];

    logic signed [36:0] den_s;
    logic [52:0]        num;
    logic               big;
    t_div_stg           stg_next [QBITS+1];

    // Denominator 1 + z2*k in Q12.24 and the floor test.
    assign den_s = 37'sd16777216 + 37'(r_prod);

    // Numerator 2^38 + den/2, and whether the quotient leaves 16 bits.
    always_comb begin
        num = (53'd1 << 38) + 53'(r_den >> 1);
        big = num >= {1'b0, r_den, 16'd0};
    end

    // One quotient bit per stage, most significant first.
    always_comb begin
        stg_next[0].valid = r_p6.valid;
        stg_next[0].sat   = r_floor || big;
        stg_next[0].rem   = num;
        stg_next[0].den   = r_den;
        stg_next[0].q     = '0;
        stg_next[0].x1    = r_p6.x1;
        stg_next[0].y2    = r_p6.y2;
        stg_next[0].z2    = r_p6.z2;
        for (int i = 0; i < QBITS; i++) begin
            stg_next[i+1] = r_stg[i];
            if (r_stg[i].rem >= (53'(r_stg[i].den) << (QBITS - 1 - i))) begin
                stg_next[i+1].rem = r_stg[i].rem - (53'(r_stg[i].den) << (QBITS - 1 - i));
                stg_next[i+1].q[QBITS-1-i] = 1'b1;
            end
        end
    end

    // Valid bits of the denominator stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5.valid <= 1'b0;
            r_p6.valid <= 1'b0;
        end else begin
            r_p5.valid <= i_pt.valid;
            r_p6.valid <= r_p5.valid;
        end
    end

    // Stage payloads; divider valid bits are cleared while reset is low.
    always_ff @(posedge i_clk) begin
        r_p5.x1 <= i_pt.x1;
        r_p5.y2 <= i_pt.y2;
        r_p5.z2 <= i_pt.z2;
        r_prod  <= 36'(i_pt.z2) * 36'($signed({1'b0, i_persp_k}));
        r_p6.x1 <= r_p5.x1;
        r_p6.y2 <= r_p5.y2;
        r_p6.z2 <= r_p5.z2;
        r_den   <= 36'(den_s);
        r_floor <= den_s <= 37'sd262144;
        for (int i = 0; i <= QBITS; i++) begin
            r_stg[i].valid <= i_rst_n && stg_next[i].valid;
            r_stg[i].sat   <= stg_next[i].sat;
            r_stg[i].rem   <= stg_next[i].rem;
            r_stg[i].den   <= stg_next[i].den;
            r_stg[i].q     <= stg_next[i].q;
            r_stg[i].x1    <= stg_next[i].x1;
            r_stg[i].y2    <= stg_next[i].y2;
            r_stg[i].z2    <= stg_next[i].z2;
        end
    end

    assign o_pf.valid = r_stg[QBITS].valid;
    assign o_pf.sat   = r_stg[QBITS].sat;
    assign o_pf.q     = r_stg[QBITS].q;
    assign o_pf.x1    = r_stg[QBITS].x1;
    assign o_pf.y2    = r_stg[QBITS].y2;
    assign o_pf.z2    = r_stg[QBITS].z2;

endmodule

>>> sv/twwp_screen.sv
// Scaling, centering and saturation of the projected point.
module twwp_screen import twwp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pf                i_pf,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic signed [19:0] o_screen_x,
    output logic signed [19:0] o_screen_y,
    output logic signed [15:0] o_depth,
    output logic [15:0]        o_persp,
    output logic               o_overflow
);

    logic               r_v1, r_v2, r_v3;
    logic [15:0]        r_pf1, r_pf2;
    logic [31:0]        r_sp;
    logic               r_ov1, r_ov2;
    logic signed [17:0] r_x1;
    logic signed [18:0] r_y2;
    logic signed [18:0] r_z2_1, r_z2_2;
    logic signed [51:0] r_px, r_py;
    logic signed [19:0] r_sx, r_sy;
    logic signed [15:0] r_dep;
    logic [15:0]        r_pf3;
    logic               r_ov3;

    logic [15:0]        pf;
    logic signed [25:0] rx, ry;
    logic signed [27:0] sx, sy;
    logic               ov_x, ov_y, ov_d;

    assign pf = i_pf.sat ? 16'hFFFF : i_pf.q;

    // Round to Q.4, place about the centre and clamp.
    always_comb begin
        rx   = 26'((r_px + 52'sd33554432) >>> 26);
        ry   = 26'((r_py + 52'sd33554432) >>> 26);
        sx   = 28'($signed({1'b0, i_cfg.centre_x})) + 28'(rx);
        sy   = 28'($signed({1'b0, i_cfg.centre_y})) - 28'(ry);
        ov_x = (sx > 28'sd524287) || (sx < -28'sd524288);
        ov_y = (sy > 28'sd524287) || (sy < -28'sd524288);
        ov_d = (r_z2_2 > 19'sd32767) || (r_z2_2 < -19'sd32768);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_pf.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Scale times factor, then coordinate times that, then the output stage.
    always_ff @(posedge i_clk) begin
        r_sp   <= 32'(i_cfg.scale) * 32'(pf);
        r_pf1  <= pf;
        r_ov1  <= i_pf.sat;
        r_x1   <= i_pf.x1;
        r_y2   <= i_pf.y2;
        r_z2_1 <= i_pf.z2;

        r_px   <= 52'(r_x1) * 52'($signed({1'b0, r_sp}));
        r_py   <= 52'(r_y2) * 52'($signed({1'b0, r_sp}));
        r_pf2  <= r_pf1;
        r_ov2  <= r_ov1;
        r_z2_2 <= r_z2_1;

        r_sx   <= (sx > 28'sd524287) ? 20'sd524287 :
                  (sx < -28'sd524288) ? -20'sd524288 : 20'(sx);
        r_sy   <= (sy > 28'sd524287) ? 20'sd524287 :
                  (sy < -28'sd524288) ? -20'sd524288 : 20'(sy);
        r_dep  <= (r_z2_2 > 19'sd32767) ? 16'sd32767 :
                  (r_z2_2 < -19'sd32768) ? -16'sd32768 : 16'(r_z2_2);
        r_pf3  <= r_pf2;
        r_ov3  <= r_ov2 || ov_x || ov_y || ov_d;
    end

    assign o_valid    = r_v3;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_depth    = r_dep;
    assign o_persp    = r_pf3;
    assign o_overflow = r_ov3;

endmodule

>>> sv/twwp_checker.sv
// Port-level checks of the projection block, bound to its top level.
module twwp_checker import twwp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [15:0] o_persp,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index
);

    // Every result comes from a request taken a fixed latency earlier.
    a_latency: assert property (@(posedge i_clk)
        o_valid |-> $past(start && !busy, 26))
        else $error("result without a matching request");

    // An angle write starts a trig reload.
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready &&
         (i_cfg_index == CFG_YAW || i_cfg_index == CFG_PITCH)) |=> busy)
        else $error("angle write did not reload trig");

    // The config port is open exactly when points can be taken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !busy)
        else $error("config ready and busy disagree");

    // The factor is never zero within the denominator range.
    a_persp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_persp != 16'd0)
        else $error("zero perspective factor");

endmodule

bind turntable_weak_perspective_project_top twwp_checker u_twwp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_persp     (o_persp),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);

>>> test/twwp_projection_checker.sv
// Checker for the turntable projection block: predicts each point and compares results.
`timescale 1ns / 100ps
module twwp_projection_checker import twwp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_atom_x,
    input  logic signed [15:0] i_atom_y,
    input  logic signed [15:0] i_atom_z,
    input  logic               o_valid,
    input  logic signed [19:0] o_screen_x,
    input  logic signed [19:0] o_screen_y,
    input  logic signed [15:0] o_depth,
    input  logic [15:0]        o_persp,
    input  logic               o_overflow,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_seen
);

    typedef struct packed {
        logic signed [19:0] sx;
        logic signed [19:0] sy;
        logic signed [15:0] dep;
        logic [15:0]        pf;
        logic               ov;
    } t_proj;

    t_proj       proj_q[$];
    logic [8:0]  yaw_r;
    logic [7:0]  pitch_r;
    logic [15:0] cx_r, cy_r, scale_r, pk_r;

    assign o_pending = proj_q.size();

    // Rounded arithmetic shift, ties toward plus infinity.
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Sine in Q1.14 of a Q0.32 turn phase, built from a truncated Taylor series.
    function automatic longint sine_q14(input logic [31:0] t);
        logic [63:0] one, r, x, x2, h, s;
        longint v;
        one = 64'd1 << 30;
        r = {34'd0, t[29:0]};
        if (t[30]) r = one - r;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        h  = one;
        h  = one - ((x2 * h) >> 30) / 110;
        h  = one - ((x2 * h) >> 30) / 72;
        h  = one - ((x2 * h) >> 30) / 42;
        h  = one - ((x2 * h) >> 30) / 20;
        h  = one - ((x2 * h) >> 30) / 6;
        s  = (x * h) >> 30;
        v  = longint'((s + 64'd32768) >> 16);
        return t[31] ? -v : v;
    endfunction

    function automatic logic [31:0] turn_phase(input int a);
        int p;
        logic [63:0] w;
        p = a % ANGLE_STEPS;
        if (p < 0) p += ANGLE_STEPS;
        w = (64'(p) << 32) / 64'(ANGLE_STEPS);
        return w[31:0];
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                     inout logic ov);
        if (v < lo) begin ov = 1'b1; return lo; end
        if (v > hi) begin ov = 1'b1; return hi; end
        return v;
    endfunction

    // Full projection of one point under the current settings.
    function automatic t_proj project_point(input longint ax, input longint ay,
                                            input longint az);
        t_proj r;
        logic ov;
        logic [31:0] ty, tp;
        longint sy, cy, sp, cp, x1, z1, y2, z2, den, pf, sx, sy2, dep;
        ov = 1'b0;
        ty = turn_phase(int'(yaw_r));
        tp = turn_phase(int'($signed(pitch_r)));
        sy = sine_q14(ty);
        cy = sine_q14(ty + 32'h4000_0000);
        sp = sine_q14(tp);
        cp = sine_q14(tp + 32'h4000_0000);
        x1 = rnd_shift(ax * cy + az * sy, 14);
        z1 = rnd_shift(az * cy - ax * sy, 14);
        y2 = rnd_shift(ay * cp - z1 * sp, 14);
        z2 = rnd_shift(ay * sp + z1 * cp, 14);
        den = (64'sd1 <<< 24) + z2 * longint'(pk_r);
        if (den <= (64'sd1 <<< 18)) begin
            pf = 65535;
            ov = 1'b1;
        end else begin
            pf = ((64'sd1 <<< 38) + den / 2) / den;
            pf = clamp(pf, 0, 65535, ov);
        end
        dep = clamp(z2, -32768, 32767, ov);
        sx  = longint'(cx_r) + rnd_shift(x1 * longint'(scale_r) * pf, 26);
        sy2 = longint'(cy_r) - rnd_shift(y2 * longint'(scale_r) * pf, 26);
        sx  = clamp(sx, -524288, 524287, ov);
        sy2 = clamp(sy2, -524288, 524287, ov);
        r.sx = sx[19:0];
        r.sy = sy2[19:0];
        r.dep = dep[15:0];
        r.pf = pf[15:0];
        r.ov = ov;
        return r;
    endfunction

    // Track settings, queue predictions and compare results, all at the clock edge.
    always @(posedge i_clk) begin
        t_proj want;
        if (!i_rst_n) begin
            yaw_r   <= 9'(YAW_RST);
            pitch_r <= 8'(PITCH_RST);
            cx_r    <= 16'(CENTRE_RST);
            cy_r    <= 16'(CENTRE_RST);
            scale_r <= 16'(SCALE_RST);
            pk_r    <= 16'(PK_RST);
            proj_q.delete();
        end else begin
            if (o_valid) begin
                o_seen <= o_seen + 1;
                if (proj_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result sx=%0d", o_screen_x);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = proj_q.pop_front();
                    if (want !== {o_screen_x, o_screen_y, o_depth, o_persp, o_overflow}) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                                     want.sx, want.sy, want.dep, want.pf, want.ov,
                                     o_screen_x, o_screen_y, o_depth, o_persp, o_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                proj_q.insert(proj_q.size(), project_point(i_atom_x, i_atom_y, i_atom_z));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_YAW:      yaw_r   <= i_cfg_data[8:0];
                    CFG_PITCH:    pitch_r <= i_cfg_data[7:0];
                    CFG_CENTRE_X: cx_r    <= i_cfg_data;
                    CFG_CENTRE_Y: cy_r    <= i_cfg_data;
                    CFG_SCALE:    scale_r <= i_cfg_data;
                    CFG_PERSP_K:  pk_r    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> test/tb_turntable_weak_perspective_project_top.sv
// Testbench top: drives points and settings into the projection block and gives the verdict.
`timescale 1ns / 100ps
module tb_turntable_weak_perspective_project_top;
    import twwp_pkg::*;

    localparam int LATENCY   = 26;
    localparam int CYCLE_CAP = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_atom_x = '0, i_atom_y = '0, i_atom_z = '0;
    logic               o_valid;
    logic signed [19:0] o_screen_x, o_screen_y;
    logic signed [15:0] o_depth;
    logic [15:0]        o_persp;
    logic               o_overflow;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    int                 fail_count, pending, seen;
    int                 cycle_count = 0;
    int                 point_count = 0;
    int                 setting_count = 0;

    always #5 i_clk = ~i_clk;

    turntable_weak_perspective_project_top DUT (.*);

    twwp_projection_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_atom_x, .i_atom_y, .i_atom_z,
        .o_valid, .o_screen_x, .o_screen_y, .o_depth, .o_persp, .o_overflow,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Hold one point request until the block takes it.
    task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] pz);
        start    <= 1'b1;
        i_atom_x <= px;
        i_atom_y <= py;
        i_atom_z <= pz;
        do @(posedge i_clk); while (busy);
        point_count++;
    endtask

    // Write one register once the block has drained.
    task automatic write_setting(input logic [2:0] idx, input logic [15:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        setting_count++;
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 2047)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_value(input logic [2:0] idx);
        case (idx)
            CFG_YAW:   return 16'($urandom_range(0, 511));
            CFG_PITCH: return 16'($urandom_range(0, 255));
            CFG_SCALE: return ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                              16'($urandom_range(0, 1024));
            CFG_PERSP_K: return ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                                16'($urandom_range(0, 600));
            default:   return 16'($urandom);
        endcase
    endfunction

    // Random points in bursts separated by idle gaps.
    task automatic random_phase(input int n);
        int gap_left;
        gap_left = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 12);
                start <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
            send_point(pick_coord(), pick_coord(), pick_coord());
        end
        start <= 1'b0;
    endtask

    initial begin
        logic [2:0] idx;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under reset settings: field extremes and zero.
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h8000, 16'h0100);
        send_point(16'h0100, 16'hFF00, 16'h8000);
        start <= 1'b0;

        // Extreme and large register values, plus two indexes past the list.
        write_setting(CFG_YAW, 16'd0);
        write_setting(CFG_PITCH, 16'h0059);
        write_setting(CFG_SCALE, 16'hFFFF);
        write_setting(CFG_CENTRE_X, 16'hFFFF);
        write_setting(CFG_CENTRE_Y, 16'hFFFF);
        send_point(16'h7FFF, 16'h8000, 16'h0000);
        send_point(16'h0001, 16'hFFFF, 16'h0001);
        write_setting(CFG_YAW, 16'd511);
        write_setting(CFG_PITCH, 16'h00A7);
        write_setting(CFG_SCALE, 16'd0);
        write_setting(CFG_CENTRE_X, 16'd0);
        send_point(16'h1234, 16'h8000, 16'h7FFF);
        // Strong perspective drives the denominator below its floor for near points.
        write_setting(CFG_SCALE, 16'd256);
        write_setting(CFG_PERSP_K, 16'hFFFF);
        send_point(16'h0100, 16'h0100, 16'h8000);
        send_point(16'h0100, 16'h0100, 16'h7FFF);
        send_point(16'h0000, 16'h0000, 16'hFF00);
        write_setting(CFG_PITCH, 16'h0080);
        write_setting(CFG_YAW, 16'd90);
        write_setting(3'd6, 16'h1234);
        write_setting(3'd7, 16'hFFFF);
        send_point(16'h0400, 16'hFC00, 16'h0200);
        send_point(16'h8000, 16'h7FFF, 16'h8000);

        // Random phases, each under fresh random settings.
        for (int ph = 0; ph < 12; ph++) begin
            for (int k = 0; k < 3; k++) begin
                idx = 3'($urandom_range(0, 7));
                write_setting(idx, pick_value(idx));
            end
            random_phase(75);
        end

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Sent %0d points with %0d register writes; %0d results compared.",
                 point_count, setting_count, seen);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
